// ===== rtl/core/ist_pkg.sv =====
// Shared types and fixed constants of the interval statistics tracker.
package ist_pkg;

  localparam int unsigned SampleBits = 32;
  localparam int unsigned WarmupBits = 16;
  localparam int unsigned PaddrBits  = 2;
  localparam int unsigned PdataBits  = 32;

  localparam logic [WarmupBits-1:0] WarmupReset   = WarmupBits'(16);
  localparam logic [SampleBits-1:0] SampleMax     = '1;
  localparam logic [PaddrBits-1:0]  RegWarmupAddr = PaddrBits'(0);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // a request is accepted this cycle
    logic step;    // one quotient bit of the mean update
    logic finish;  // apply the quotient to the running mean
    logic load;    // copy the statistics into the output register
  } ist_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic record;    // warm-up is over, the next interval is recorded
    logic out_free;  // the output register can take a new result
  } ist_status_t;

endpackage

// ===== rtl/core/ist_in_if.sv =====
// Request channel carrying one timestamp.
interface ist_in_if #(
  parameter int unsigned STAMP_BITS = 48
);
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink (input valid, input timestamp, output ready);
endinterface

// ===== rtl/core/ist_out_if.sv =====
// Result channel carrying the interval statistics.
interface ist_out_if #(
  parameter int unsigned STAMP_BITS     = 48,
  parameter int unsigned MEAN_FRAC_BITS = 8
);
  logic                                 valid;
  logic                                 ready;
  logic [STAMP_BITS-1:0]                min_interval;
  logic [STAMP_BITS-1:0]                max_interval;
  logic [STAMP_BITS+MEAN_FRAC_BITS-1:0] mean_interval;
  logic [31:0]                          sample_total;
  logic                                 has_samples;

  modport source (output valid, output min_interval, output max_interval,
                  output mean_interval, output sample_total, output has_samples,
                  input ready);
  modport sink (input valid, input min_interval, input max_interval,
                input mean_interval, input sample_total, input has_samples,
                output ready);
endinterface

// ===== rtl/core/ist_ctrl.sv =====
// Controller state machine of the interval statistics tracker.
module ist_ctrl
  import ist_pkg::*;
#(
  parameter int unsigned MEAN_BITS = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ist_status_t status_i,
  output ist_cmd_t    cmd_o
);

  localparam int unsigned CntBits = $clog2(MEAN_BITS);
  localparam logic [CntBits-1:0] LastStep = CntBits'(MEAN_BITS - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = status_i.record ? StDiv : StEmit;
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CntBits'(1);
        if (cnt_q == LastStep) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d      = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/ist_dpath.sv =====
// Datapath of the interval statistics tracker: state, divider and output register.
module ist_dpath
  import ist_pkg::*;
#(
  parameter int unsigned STAMP_BITS     = 48,
  parameter int unsigned MEAN_FRAC_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [STAMP_BITS-1:0]                timestamp_i,
  input  logic [WarmupBits-1:0]                warmup_i,
  input  ist_cmd_t                             cmd_i,
  output ist_status_t                          status_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [STAMP_BITS-1:0]                min_o,
  output logic [STAMP_BITS-1:0]                max_o,
  output logic [STAMP_BITS+MEAN_FRAC_BITS-1:0] mean_o,
  output logic [SampleBits-1:0]                samples_o,
  output logic                                 has_samples_o
);

  localparam int unsigned MeanBits = STAMP_BITS + MEAN_FRAC_BITS;

  logic [STAMP_BITS-1:0] prev_q;
  logic [WarmupBits-1:0] cycles_q;
  logic [SampleBits-1:0] samples_q;
  logic [STAMP_BITS-1:0] min_q, max_q;
  logic [MeanBits-1:0]   mean_q;

  // Divider: the dividend register collects the quotient as it shifts.
  logic [MeanBits-1:0]   dvd_q;
  logic [SampleBits-1:0] rem_q, div_q;
  logic                  neg_q;

  logic                  out_valid_q;
  logic [STAMP_BITS-1:0] out_min_q, out_max_q;
  logic [MeanBits-1:0]   out_mean_q;
  logic [SampleBits-1:0] out_samples_q;

  logic [STAMP_BITS-1:0] interval;
  logic [MeanBits-1:0]   x_val;
  logic                  x_ge;
  logic [SampleBits-1:0] samples_next;
  logic [SampleBits:0]   rem_sh, rem_sub;
  logic                  q_bit;

  assign interval     = timestamp_i - prev_q;
  assign x_val        = MeanBits'(interval) << MEAN_FRAC_BITS;
  assign x_ge         = (x_val >= mean_q);
  assign samples_next = (samples_q != SampleMax) ? samples_q + SampleBits'(1) : samples_q;

  assign rem_sh  = {rem_q, dvd_q[MeanBits-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign q_bit   = (rem_sh >= {1'b0, div_q});

  assign status_o.record   = (cycles_q >= warmup_i);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      cycles_q  <= '0;
      samples_q <= '0;
      min_q     <= '1;
      max_q     <= '0;
      mean_q    <= '0;
    end else begin
      if (cmd_i.start) begin
        prev_q <= timestamp_i;
        if (status_o.record) begin
          samples_q <= samples_next;
          if (interval < min_q) begin
            min_q <= interval;
          end
          if (interval > max_q) begin
            max_q <= interval;
          end
        end else begin
          cycles_q <= cycles_q + WarmupBits'(1);
        end
      end
      if (cmd_i.finish) begin
        mean_q <= neg_q ? mean_q - dvd_q : mean_q + dvd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q <= x_ge ? x_val - mean_q : mean_q - x_val;
      neg_q <= !x_ge;
      div_q <= samples_next;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      dvd_q <= {dvd_q[MeanBits-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[SampleBits-1:0] : rem_sh[SampleBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_min_q     <= min_q;
      out_max_q     <= max_q;
      out_mean_q    <= mean_q;
      out_samples_q <= samples_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_o         = out_min_q;
  assign max_o         = out_max_q;
  assign mean_o        = out_mean_q;
  assign samples_o     = out_samples_q;
  assign has_samples_o = (out_samples_q != '0);

endmodule

// ===== rtl/core/interval_statistics_tracker.sv =====
// Top level of the interval statistics tracker with its configuration register.
//
// Each request carries one timestamp of a free-running counter and yields one result
// with the smallest, largest and running mean interval between timestamps, the number
// of recorded intervals and a flag that is set once one has been recorded. The first
// warmup_cycles requests (register 0, byte address 0, reset value 16) only count and
// record nothing. For an interval that is recorded, the mean update divides by the
// sample count in a restoring divider that produces one quotient bit per cycle,
// applies the quotient to the mean and then loads the result. A request during
// warm-up skips the divider and goes straight to loading its result. A result that
// is still waiting to be read when the next one is ready to load adds those waiting
// cycles as a stall. One request is in flight at a time; the next is taken once its
// result sits in the output register, while that result still waits to be read.
// The mean is unsigned fixed point with MEAN_FRAC_BITS fractional bits and every
// division truncates toward zero.
module interval_statistics_tracker
  import ist_pkg::*;
#(
  parameter int unsigned STAMP_BITS     = 48,
  parameter int unsigned MEAN_FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ist_in_if.sink               item_i,
  ist_out_if.source            stats_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [PdataBits-1:0] pwdata,
  output logic [PdataBits-1:0] prdata,
  output logic                 pready
);

  localparam int unsigned MeanBits = STAMP_BITS + MEAN_FRAC_BITS;

  logic [WarmupBits-1:0] warmup_q;
  logic                  cfg_write;
  ist_cmd_t              cmd;
  ist_status_t           status;

  // The register port never waits; only the warm-up register is decoded.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == RegWarmupAddr);
  assign prdata    = (paddr == RegWarmupAddr) ? PdataBits'(warmup_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_q <= WarmupReset;
    end else if (cfg_write) begin
      warmup_q <= pwdata[WarmupBits-1:0];
    end
  end

  ist_ctrl #(
    .MEAN_BITS (MeanBits)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ist_dpath #(
    .STAMP_BITS     (STAMP_BITS),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timestamp_i   (item_i.timestamp),
    .warmup_i      (warmup_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (stats_o.ready),
    .out_valid_o   (stats_o.valid),
    .min_o         (stats_o.min_interval),
    .max_o         (stats_o.max_interval),
    .mean_o        (stats_o.mean_interval),
    .samples_o     (stats_o.sample_total),
    .has_samples_o (stats_o.has_samples)
  );

endmodule

// ===== rtl/core/ist_checker.sv =====
// Port-level checker of the interval statistics tracker and its bind.
module ist_checker #(
  parameter int unsigned STAMP_BITS     = 48,
  parameter int unsigned MEAN_FRAC_BITS = 8
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [STAMP_BITS-1:0]                min_interval,
  input logic [STAMP_BITS-1:0]                max_interval,
  input logic [STAMP_BITS+MEAN_FRAC_BITS-1:0] mean_interval,
  input logic [31:0]                          sample_total,
  input logic                                 has_samples
);

  localparam int unsigned MeanBits = STAMP_BITS + MEAN_FRAC_BITS;

  // A result that is offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in flight");

  // The sample flag agrees with the sample count.
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (has_samples == (sample_total != 32'd0)))
    else $error("sample flag disagrees with sample count");

  // With samples, the mean lies between the smallest and the largest interval.
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && has_samples |->
      (min_interval <= max_interval) &&
      (mean_interval >= (MeanBits'(min_interval) << MEAN_FRAC_BITS)) &&
      (mean_interval <= (MeanBits'(max_interval) << MEAN_FRAC_BITS)))
    else $error("mean outside the recorded interval range");

endmodule

bind interval_statistics_tracker ist_checker #(
  .STAMP_BITS     (STAMP_BITS),
  .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
) u_ist_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (item_i.valid),
  .in_ready      (item_i.ready),
  .out_valid     (stats_o.valid),
  .out_ready     (stats_o.ready),
  .min_interval  (stats_o.min_interval),
  .max_interval  (stats_o.max_interval),
  .mean_interval (stats_o.mean_interval),
  .sample_total  (stats_o.sample_total),
  .has_samples   (stats_o.has_samples)
);

// ===== sim/interval_statistics_tracker_checker.sv =====
// Watches the tracker's channels and register port, predicts each result and compares it.
module interval_statistics_tracker_checker
  import ist_pkg::*;
#(
  parameter int unsigned STAMP_BITS     = 48,
  parameter int unsigned MEAN_FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ist_in_if                    item_i,
  ist_out_if                   stats_i,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [PdataBits-1:0] pwdata,
  input  logic [PdataBits-1:0] prdata,
  input  logic                 pready,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MeanBits = STAMP_BITS + MEAN_FRAC_BITS;

  typedef struct packed {
    logic [STAMP_BITS-1:0] min_interval;
    logic [STAMP_BITS-1:0] max_interval;
    logic [MeanBits-1:0]   mean_interval;
    logic [SampleBits-1:0] sample_total;
    logic                  has_samples;
  } stats_t;

  // Mirror of the tracker's register and statistics.
  logic [WarmupBits-1:0] warmup_limit;
  logic [WarmupBits-1:0] warm_count;
  logic [STAMP_BITS-1:0] last_stamp;
  logic [SampleBits-1:0] interval_count;
  logic [STAMP_BITS-1:0] min_seen;
  logic [STAMP_BITS-1:0] max_seen;
  logic [MeanBits-1:0]   mean_acc;

  stats_t      stats_queue[$];
  int unsigned failures;
  int unsigned results_seen;

  initial begin
    failures     = 0;
    results_seen = 0;
  end

  function automatic void clear_tracker();
    warmup_limit   = WarmupReset;
    warm_count     = '0;
    last_stamp     = '0;
    interval_count = '0;
    min_seen       = '1;
    max_seen       = '0;
    mean_acc       = '0;
  endfunction

  // Updates the statistics for one timestamp and returns what the tracker should report.
  function automatic stats_t advance_tracker(input logic [STAMP_BITS-1:0] stamp);
    logic [STAMP_BITS-1:0] interval;
    logic [MeanBits-1:0]   scaled;
    stats_t                res;
    if (warm_count >= warmup_limit) begin
      interval = stamp - last_stamp;
      scaled   = MeanBits'(interval) << MEAN_FRAC_BITS;
      if (interval > max_seen) max_seen = interval;
      if (interval < min_seen) min_seen = interval;
      if (interval_count != SampleMax) interval_count = interval_count + 1'b1;
      // Welford step on magnitudes, so the mean stays between its old value and x.
      if (scaled >= mean_acc) begin
        mean_acc = mean_acc + (scaled - mean_acc) / MeanBits'(interval_count);
      end else begin
        mean_acc = mean_acc - (mean_acc - scaled) / MeanBits'(interval_count);
      end
    end else begin
      warm_count = warm_count + 1'b1;
    end
    last_stamp        = stamp;
    res.min_interval  = min_seen;
    res.max_interval  = max_seen;
    res.mean_interval = mean_acc;
    res.sample_total  = interval_count;
    res.has_samples   = (interval_count != '0);
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  function automatic void check_result();
    stats_t got;
    stats_t want;
    got.min_interval  = stats_i.min_interval;
    got.max_interval  = stats_i.max_interval;
    got.mean_interval = stats_i.mean_interval;
    got.sample_total  = stats_i.sample_total;
    got.has_samples   = stats_i.has_samples;
    results_seen++;
    if (stats_queue.size() == 0) begin
      note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = stats_queue.pop_front();
      if (got !== want) begin
        note_failure($sformatf({"result %0d: expected min %h max %h mean %h total %0d has %0b,",
                                " got min %h max %h mean %h total %0d has %0b"},
                               results_seen, want.min_interval, want.max_interval,
                               want.mean_interval, want.sample_total, want.has_samples,
                               got.min_interval, got.max_interval, got.mean_interval,
                               got.sample_total, got.has_samples));
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_tracker();
      stats_queue.delete();
      pending_o    <= 0;
      fail_count_o <= failures;
    end else begin
      // Results leave before the request of the same edge can have produced one.
      if (stats_i.valid && stats_i.ready) check_result();
      if (item_i.valid && item_i.ready) begin
        stats_queue.push_back(advance_tracker(item_i.timestamp));
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == RegWarmupAddr) warmup_limit = pwdata[WarmupBits-1:0];
        end else if (paddr == RegWarmupAddr && prdata !== PdataBits'(warmup_limit)) begin
          note_failure($sformatf("warm-up register read: expected %h, got %h",
                                 PdataBits'(warmup_limit), prdata));
        end
      end
      pending_o    <= stats_queue.size();
      fail_count_o <= failures;
    end
  end

endmodule

// ===== sim/interval_statistics_tracker_tb.sv =====
// Testbench top: drives timestamps and warm-up settings into the tracker and reports the verdict.
module interval_statistics_tracker_tb
  import ist_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StampBits    = 48;
  localparam int unsigned MeanFracBits = 8;
  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned RandomItems  = 400;
  // Long enough for a recorded interval's division; leave some margin.
  localparam int unsigned SettleCycles = StampBits + MeanFracBits + 8;
  // Upper bound on the length of the slowest legal run.
  localparam int unsigned CycleLimit   = 600_000;
  // An address with no register behind it; writes there must be dropped.
  localparam logic [PaddrBits-1:0] UnusedAddr = PaddrBits'(3);

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrBits-1:0] paddr;
  logic [PdataBits-1:0] pwdata;
  logic [PdataBits-1:0] prdata;
  logic                 pready;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          cycle_count = 0;
  int unsigned          items_sent = 0;
  int unsigned          settings_used = 0;

  // The free-running counter that the random timestamps follow.
  logic [StampBits-1:0] stamp_now;
  // Idling switches; one off keeps that channel busy, both off give a stretch of full throughput.
  bit                   tx_idle_on = 1'b1;
  bit                   rx_idle_on = 1'b1;

  ist_in_if #(.STAMP_BITS(StampBits)) item_if ();
  ist_out_if #(.STAMP_BITS(StampBits), .MEAN_FRAC_BITS(MeanFracBits)) stats_if ();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  interval_statistics_tracker #(
    .STAMP_BITS    (StampBits),
    .MEAN_FRAC_BITS(MeanFracBits)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .stats_o(stats_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  interval_statistics_tracker_checker #(
    .STAMP_BITS    (StampBits),
    .MEAN_FRAC_BITS(MeanFracBits)
  ) stats_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .stats_i     (stats_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("FAIL interval_statistics_tracker");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then a long one that can outlast a whole division.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) begin
      idle_len = 0;
    end else if (roll < 85) begin
      idle_len = $urandom_range(3, 1);
    end else if (roll < 97) begin
      idle_len = $urandom_range(20, 4);
    end else begin
      idle_len = $urandom_range(90, 30);
    end
  endfunction

  // Next timestamp of a well-behaved counter, with occasional jumps and plain noise.
  function automatic logic [StampBits-1:0] next_stamp();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 65) begin
      // Typical task period.
      stamp_now = stamp_now + StampBits'($urandom_range(5000, 1));
    end else if (roll < 75) begin
      // A very long interval.
      stamp_now = stamp_now + StampBits'({$urandom(), $urandom()});
    end else if (roll < 82) begin
      // Park just below the top so that the next steps wrap the counter.
      stamp_now = '1 - StampBits'($urandom_range(3000, 0));
    end else if (roll >= 88) begin
      // Noise: an arbitrary value, often behind the previous one.
      stamp_now = StampBits'({$urandom(), $urandom()});
    end
    // The remaining rolls repeat the previous stamp, which gives a zero interval.
    next_stamp = stamp_now;
  endfunction

  // Offers one request and returns at the edge where it is accepted, then maybe idles.
  task automatic send_stamp(input logic [StampBits-1:0] stamp);
    int unsigned gap;
    item_if.valid     <= 1'b1;
    item_if.timestamp <= stamp;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every expected result has been taken by the receiver.
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Register access: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic [PaddrBits-1:0] addr, input logic [PdataBits-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The checker compares prdata at the access edge.
  task automatic reg_read(input logic [PaddrBits-1:0] addr);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the warm-up count with junk in the unused upper bits and reads it back.
  task automatic apply_warmup(input logic [WarmupBits-1:0] cycles);
    reg_write(RegWarmupAddr, {(PdataBits - WarmupBits)'($urandom()), cycles});
    reg_read(RegWarmupAddr);
    settings_used++;
  endtask

  // Result side: ready drops for random stretches while rx_idle_on is set.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    stats_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && rx_idle_on && $urandom_range(99, 0) < 30) hold_left = idle_len();
      if (hold_left != 0) begin
        stats_if.ready <= 1'b0;
        hold_left--;
      end else begin
        stats_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned           phase;
    int unsigned           len;
    int unsigned           random_sent;
    logic [WarmupBits-1:0] warm;
    rst_ni            <= 1'b0;
    item_if.valid     <= 1'b0;
    item_if.timestamp <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    phase       = 0;
    random_sent = 0;
    stamp_now   = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The register must come out of reset at its default.
    reg_read(RegWarmupAddr);

    // With no warm-up right after reset, the first interval is measured from zero.
    apply_warmup('0);
    send_stamp(48'h0000_0000_0400);
    // Largest possible timestamp, then a wrap to a short interval.
    send_stamp(48'hFFFF_FFFF_FFFF);
    send_stamp(48'h0000_0000_0002);
    // Same stamp twice gives a zero interval, the new minimum.
    send_stamp(48'h0000_0000_0002);
    // One tick backwards is the full-scale interval, twice in a row.
    send_stamp(48'h0000_0000_0001);
    send_stamp(48'h0000_0000_0000);
    // Alternating bit patterns toggle every timestamp bit.
    send_stamp(48'hAAAA_AAAA_AAAA);
    send_stamp(48'h5555_5555_5555);

    // A write to an address with no register must leave the warm-up count alone.
    wait_drained();
    reg_write(UnusedAddr, '1);
    reg_read(RegWarmupAddr);
    send_stamp(48'h5555_5555_6000);

    // Maximum warm-up: these requests only advance the warm-up count.
    wait_drained();
    apply_warmup('1);
    send_stamp(48'h5555_5555_7000);
    send_stamp(48'h5555_5555_7100);
    send_stamp(48'h5555_5555_7200);

    // Warm-up lowered below the count already reached: recording resumes at once.
    wait_drained();
    apply_warmup(WarmupBits'(1));
    send_stamp(48'h5555_5555_7300);
    send_stamp(48'h5555_5555_7380);
    send_stamp(48'h5555_5555_7390);

    // Warm-up raised past the count: two more counting requests, then recording.
    wait_drained();
    apply_warmup(WarmupBits'(5));
    send_stamp(48'h5555_5555_8000);
    send_stamp(48'h5555_5555_9000);
    send_stamp(48'h5555_5555_9100);
    send_stamp(48'h5555_5555_9400);
    stamp_now = 48'h5555_5555_9400;

    // Random phases, each under its own warm-up setting and idling pattern.
    while (random_sent < RandomItems) begin
      wait_drained();
      if (phase == 2) begin
        warm = '1;
      end else if (phase == 4) begin
        warm = '0;
      end else begin
        case ($urandom_range(3, 0))
          0, 1:    warm = WarmupBits'($urandom_range(40, 0));
          2:       warm = WarmupBits'($urandom_range(400, 41));
          default: warm = WarmupBits'($urandom());
        endcase
      end
      apply_warmup(warm);
      tx_idle_on = ($urandom_range(3, 0) != 0);
      rx_idle_on = ($urandom_range(3, 0) != 0);
      // A warm-up that cannot end within the run gets a short phase.
      len = (warm > 400) ? 8 : $urandom_range(60, 25);
      for (int unsigned i = 0; i < len; i++) begin
        // Once mid-phase, let the tracker run completely dry before going on.
        if (phase == 1 && i == len / 2) wait_drained();
        send_stamp(next_stamp());
      end
      random_sent += len;
      phase++;
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d timestamps under %0d warm-up settings, idling on both channels.",
             items_sent, settings_used);
    $display("Intervals ran from zero to full scale, with counter wraps and warm-up changes.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS interval_statistics_tracker");
    end else begin
      $display("%0d failures, %0d results outstanding.", fail_count, pending);
      $display("FAIL interval_statistics_tracker");
    end
    $finish;
  end

endmodule

// ===== interval_statistics_tracker.f =====
rtl/core/ist_pkg.sv
rtl/core/ist_in_if.sv
rtl/core/ist_out_if.sv
rtl/core/ist_ctrl.sv
rtl/core/ist_dpath.sv
rtl/core/interval_statistics_tracker.sv
rtl/core/ist_checker.sv
sim/interval_statistics_tracker_checker.sv
sim/interval_statistics_tracker_tb.sv
